// ===== rtl/base64_stream_decoder_top_defines.svh =====
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define B64D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64d check failed");

// next-cycle implication
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64d check failed");

`endif

// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

    localparam logic [1:0] KIND_CLEAN = 2'd0;
    localparam logic [1:0] KIND_PAD   = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    localparam logic [7:0] CHAR_PAD   = 8'h3d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // one queued job: up to three results, the last one may close the message
    typedef struct packed {
        logic [1:0]      nres;
        logic            valid;
        logic            eom;
        logic [1:0]      kind;
        logic [2:0][7:0] bytes;
    } t_job;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet    s;
        logic [7:0] t;
        s = '0;
        t = '0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            t = c - 8'h41;
            s = '{ok: 1'b1, val: t[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            t = c - 8'h47;
            s = '{ok: 1'b1, val: t[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c + 8'h04;
            s = '{ok: 1'b1, val: t[5:0]};
        end else if (c == CHAR_PLUS) begin
            s = '{ok: 1'b1, val: 6'd62};
        end else if (c == CHAR_SLASH) begin
            s = '{ok: 1'b1, val: 6'd63};
        end
        return s;
    endfunction

    function automatic logic [7:0] byte0(input logic [5:0] s0, input logic [5:0] s1);
        return {s0, s1[5:4]};
    endfunction

    function automatic logic [7:0] byte1(input logic [5:0] s1, input logic [5:0] s2);
        return {s1[3:0], s2[5:2]};
    endfunction

    function automatic logic [7:0] byte2(input logic [5:0] s2, input logic [5:0] s3);
        return {s2[1:0], s3};
    endfunction

    // bytes due from a partial group of g sextets
    function automatic logic [1:0] flush_count(input logic [1:0] g);
        logic [1:0] n;
        n = 2'd0;
        if (g == 2'd3) begin
            n = 2'd2;
        end else if (g == 2'd2) begin
            n = 2'd1;
        end
        return n;
    endfunction

endpackage

// ===== rtl/base64_stream_decoder_top.sv =====
// Streaming base64 decoder, standard alphabet. One character is taken per
// cycle whenever full is low; the front end classifies it and turns it into a
// job of zero to three results, which waits in a job queue of QUEUE_DEPTH
// entries. The back end hands out one result per cycle on the output queue
// port while pop is high. No message yields more results than characters, so
// with pop held high the output keeps up and the input runs at one character
// per cycle; the three results of a full group drain while the following
// characters are taken, and full only rises when the output is held off. A
// result is registered in the job queue and then in the back end's job
// register before it shows on the output ports. Decoding stops at the first
// '=' or non-alphabet character; the last result of each message carries the
// end mark and the termination kind, and a marker result with no byte is
// given when nothing else is due at the end.
`include "base64_stream_decoder_top_defines.svh"

module base64_stream_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_encoded_char,
    input  logic       i_end_of_input,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_output,
    output logic [1:0] o_termination_kind
);
    import b64d_pkg::*;

    t_job w_front_job, w_q_job;
    logic w_front_push, w_q_full, w_q_empty, w_q_pop, w_accept;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    b64d_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_encoded_char (i_encoded_char),
        .i_end_of_input (i_end_of_input),
        .o_job_push     (w_front_push),
        .o_job          (w_front_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_job   (w_q_job)
    );

    b64d_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (w_q_empty),
        .i_job              (w_q_job),
        .o_q_pop            (w_q_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_data_byte        (o_data_byte),
        .o_byte_valid       (o_byte_valid),
        .o_end_of_output    (o_end_of_output),
        .o_termination_kind (o_termination_kind)
    );

    `B64D_ASSERT_NOW(a_marker_ends, i_clk, i_rst_n, !empty && !o_byte_valid,
        o_end_of_output && o_data_byte == 8'd0)
    `B64D_ASSERT_NOW(a_kind_on_end, i_clk, i_rst_n, !empty && o_termination_kind != KIND_CLEAN,
        o_end_of_output && (o_termination_kind == KIND_PAD || o_termination_kind == KIND_BAD))
    `B64D_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_q_pop, !empty)

endmodule

// ===== rtl/b64d_front.sv =====
module b64d_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_encoded_char,
    input  logic                i_end_of_input,
    output logic                o_job_push,
    output b64d_pkg::t_job      o_job
);
    import b64d_pkg::*;

    logic [1:0]      r_gc, n_gc;
    logic [2:0][5:0] r_s, n_s;
    logic            r_stopped, n_stopped;
    logic [1:0]      r_stopk, n_stopk;

    t_sextet         w_sx;
    logic [2:0][5:0] w_s;
    logic [1:0]      w_cnt;
    logic [1:0]      w_kind;
    logic [1:0]      w_bad_kind;

    always_comb begin
        w_sx       = sextet_of(i_encoded_char);
        w_bad_kind = (i_encoded_char == CHAR_PAD) ? KIND_PAD : KIND_BAD;
        w_s        = r_s;
        w_cnt      = 2'd0;
        w_kind     = KIND_CLEAN;
        n_gc       = r_gc;
        n_s        = r_s;
        n_stopped  = r_stopped;
        n_stopk    = r_stopk;
        if (r_stopped) begin
            w_kind = r_stopk;
        end else if (!w_sx.ok) begin
            w_cnt     = flush_count(r_gc);
            w_kind    = w_bad_kind;
            n_stopped = 1'b1;
            n_stopk   = w_bad_kind;
            n_gc      = 2'd0;
        end else if (r_gc == 2'd3) begin
            w_cnt = 2'd3;
            n_gc  = 2'd0;
        end else begin
            w_s[r_gc] = w_sx.val;
            n_s       = w_s;
            n_gc      = r_gc + 2'd1;
            if (i_end_of_input) begin
                w_cnt = flush_count(r_gc + 2'd1);
            end
        end
        if (i_end_of_input) begin
            n_gc      = 2'd0;
            n_stopped = 1'b0;
            n_stopk   = KIND_CLEAN;
        end
    end

    always_comb begin
        o_job_push     = i_accept && (w_cnt != 2'd0 || i_end_of_input);
        o_job.nres     = (w_cnt == 2'd0) ? 2'd1 : w_cnt;
        o_job.valid    = (w_cnt != 2'd0);
        o_job.eom      = i_end_of_input;
        o_job.kind     = i_end_of_input ? w_kind : KIND_CLEAN;
        o_job.bytes[0] = byte0(w_s[0], w_s[1]);
        o_job.bytes[1] = byte1(w_s[1], w_s[2]);
        o_job.bytes[2] = byte2(w_s[2], w_sx.val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc      <= 2'd0;
            r_stopped <= 1'b0;
            r_stopk   <= KIND_CLEAN;
        end else if (i_accept) begin
            r_gc      <= n_gc;
            r_stopped <= n_stopped;
            r_stopk   <= n_stopk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (i_accept) begin
            r_s <= n_s;
        end
    end

endmodule

// ===== rtl/b64d_queue.sv =====
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output b64d_pkg::t_job o_job
);
    import b64d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr_en, w_rd_en;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/b64d_back.sv =====
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  b64d_pkg::t_job i_job,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_data_byte,
    output logic           o_byte_valid,
    output logic           o_end_of_output,
    output logic [1:0]     o_termination_kind
);
    import b64d_pkg::*;

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       w_last, w_take;

    assign w_last  = (r_idx == r_job.nres - 2'd1);
    assign w_take  = r_busy && i_pop;
    assign o_q_pop = !i_q_empty && (!r_busy || (w_take && w_last));

    assign o_empty            = !r_busy;
    assign o_byte_valid       = r_job.valid;
    assign o_data_byte        = r_job.valid ? r_job.bytes[r_idx] : 8'd0;
    assign o_end_of_output    = r_job.eom && w_last;
    assign o_termination_kind = (r_job.eom && w_last) ? r_job.kind : KIND_CLEAN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_take) begin
            if (w_last) begin
                r_busy <= 1'b0;
                r_idx  <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
        end
    end

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int RAND_ITEMS   = 360;
    localparam int STALL_CYCLES = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       eom;
        logic [1:0] kind;
    } t_word;

    class byte_scoreboard;
        t_word      due_words[$];
        t_word      step_words[$];
        int         errors;
        logic [1:0] grp_cnt;
        logic [5:0] held[3];
        logic       halted;
        logic [1:0] halt_kind;

        function new();
            errors = 0;
            clear_message();
        endfunction

        static function bit alphabet_value(input logic [7:0] c, output logic [5:0] v);
            v = '0;
            if (c >= "A" && c <= "Z") begin
                v = 6'(c - "A");
            end else if (c >= "a" && c <= "z") begin
                v = 6'(c - "a" + 8'd26);
            end else if (c >= "0" && c <= "9") begin
                v = 6'(c - "0" + 8'd52);
            end else if (c == CHAR_PLUS) begin
                v = 6'd62;
            end else if (c == CHAR_SLASH) begin
                v = 6'd63;
            end else begin
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void clear_message();
            grp_cnt   = 2'd0;
            held[0]   = '0;
            held[1]   = '0;
            held[2]   = '0;
            halted    = 1'b0;
            halt_kind = KIND_CLEAN;
        endfunction

        function void add_byte(input logic [7:0] b);
            step_words.push_back({b, 1'b1, 1'b0, KIND_CLEAN});
        endfunction

        function void flush_group();
            if (grp_cnt >= 2'd2) begin
                add_byte({held[0], held[1][5:4]});
            end
            if (grp_cnt == 2'd3) begin
                add_byte({held[1][3:0], held[2][5:2]});
            end
        endfunction

        function void close_message(input logic [1:0] kind);
            if (step_words.size() == 0) begin
                step_words.push_back({8'h00, 1'b0, 1'b1, kind});
            end else begin
                step_words[step_words.size() - 1].eom  = 1'b1;
                step_words[step_words.size() - 1].kind = kind;
            end
            clear_message();
        endfunction

        // returns 1 unless the char is skipped after a stop
        function bit note_char(input logic [7:0] c, input logic last);
            logic [5:0] v;
            bit         ok;
            bit         used;
            step_words.delete();
            used = 1'b1;
            if (halted) begin
                used = last;
                if (last) begin
                    close_message(halt_kind);
                end
            end else begin
                ok = alphabet_value(c, v);
                if (!ok) begin
                    halted    = 1'b1;
                    halt_kind = (c == CHAR_PAD) ? KIND_PAD : KIND_BAD;
                    flush_group();
                    grp_cnt = 2'd0;
                    if (last) begin
                        close_message(halt_kind);
                    end
                end else if (grp_cnt == 2'd3) begin
                    add_byte({held[0], held[1][5:4]});
                    add_byte({held[1][3:0], held[2][5:2]});
                    add_byte({held[2][1:0], v});
                    grp_cnt = 2'd0;
                    if (last) begin
                        close_message(KIND_CLEAN);
                    end
                end else begin
                    held[grp_cnt] = v;
                    grp_cnt = grp_cnt + 2'd1;
                    if (last) begin
                        flush_group();
                        close_message(KIND_CLEAN);
                    end
                end
            end
            foreach (step_words[i]) begin
                due_words.push_back(step_words[i]);
            end
            return used;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        task report(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_word(input t_word got);
            t_word want;
            if (due_words.size() == 0) begin
                report($sformatf("unexpected word %h", got));
            end else begin
                want = due_words.pop_front();
                if (got.data !== want.data) begin
                    report($sformatf("data_byte %h, want %h", got.data, want.data));
                end
                if (got.valid !== want.valid) begin
                    report($sformatf("byte_valid %b, want %b", got.valid, want.valid));
                end
                if (got.eom !== want.eom) begin
                    report($sformatf("end_of_output %b, want %b", got.eom, want.eom));
                end
                if (got.kind !== want.kind) begin
                    report($sformatf("termination_kind %0d, want %0d", got.kind, want.kind));
                end
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_encoded_char;
    logic       i_end_of_input;
    logic       empty;
    logic       pop;
    logic [7:0] o_data_byte;
    logic       o_byte_valid;
    logic       o_end_of_output;
    logic [1:0] o_termination_kind;

    byte_scoreboard sb;
    logic [7:0]     msg_chars[$];
    int             fed_count;
    int             stall_asks;
    bit             tx_idling;
    bit             rx_idling;

    base64_stream_decoder_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_encoded_char     (i_encoded_char),
        .i_end_of_input     (i_end_of_input),
        .empty              (empty),
        .pop                (pop),
        .o_data_byte        (o_data_byte),
        .o_byte_valid       (o_byte_valid),
        .o_end_of_output    (o_end_of_output),
        .o_termination_kind (o_termination_kind)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] random_alpha();
        int idx;
        idx = $urandom_range(63);
        if (idx < 26) begin
            return "A" + 8'(idx);
        end else if (idx < 52) begin
            return "a" + 8'(idx - 26);
        end else if (idx < 62) begin
            return "0" + 8'(idx - 52);
        end else if (idx == 62) begin
            return CHAR_PLUS;
        end
        return CHAR_SLASH;
    endfunction

    function automatic logic [7:0] random_stop_char();
        logic [7:0] c;
        logic [5:0] v;
        if ($urandom_range(2) == 0) begin
            return CHAR_PAD;
        end
        do begin
            c = 8'($urandom_range(255));
        end while (byte_scoreboard::alphabet_value(c, v));
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        while (tx_idling && $urandom_range(99) < 18) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_encoded_char <= c;
        i_end_of_input <= last;
        do @(posedge i_clk); while (full);
        if (sb.note_char(c, last)) begin
            fed_count++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_msg();
        foreach (msg_chars[i]) begin
            send_char(msg_chars[i], i == msg_chars.size() - 1);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic build_message();
        int pick;
        int pad;
        msg_chars.delete();
        pick = $urandom_range(99);
        if (pick < 60) begin
            pad = $urandom_range(2);
            repeat (4 * $urandom_range(5)) msg_chars.push_back(random_alpha());
            if (msg_chars.size() == 0 && pad == 0) begin
                pad = 1;
            end
            if (pad == 1) begin
                repeat (2) msg_chars.push_back(random_alpha());
                repeat (2) msg_chars.push_back(CHAR_PAD);
            end else if (pad == 2) begin
                repeat (3) msg_chars.push_back(random_alpha());
                msg_chars.push_back(CHAR_PAD);
            end
        end else if (pick < 75) begin
            repeat ($urandom_range(7)) msg_chars.push_back(random_alpha());
            msg_chars.push_back(random_stop_char());
            repeat ($urandom_range(3)) msg_chars.push_back(8'($urandom_range(255)));
        end else if (pick < 90) begin
            repeat ($urandom_range(9, 1)) msg_chars.push_back(random_alpha());
        end else begin
            repeat ($urandom_range(6, 1)) msg_chars.push_back(8'($urandom_range(255)));
        end
    endtask

    // output side: checks each popped word, idles at random, honors hold-off requests
    initial begin : receiver
        int    stalls_seen;
        int    stall_left;
        t_word got;
        stalls_seen = 0;
        stall_left  = 0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got = {o_data_byte, o_byte_valid, o_end_of_output, o_termination_kind};
                sb.check_word(got);
            end
            if (stalls_seen != stall_asks) begin
                stalls_seen = stall_asks;
                stall_left  = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= !(rx_idling && $urandom_range(99) < 18);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int rand_start;
        bit stall_done;
        bit pause_done;
        sb         = new();
        fed_count  = 0;
        stall_asks = 0;
        stall_done = 1'b0;
        pause_done = 1'b0;
        tx_idling  = 1'b1;
        rx_idling  = 1'b1;
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_encoded_char <= 8'h00;
        i_end_of_input <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full group, all-ones bytes with pad stop, lone char, padded tail
        send_text("TWFu");
        send_text("//8=");
        send_text("A");
        send_text("Zm9vYQ==");
        // high-bit char stops, later chars skipped
        send_char("z", 1'b0);
        send_char("z", 1'b0);
        send_char(8'hff, 1'b0);
        send_char("x", 1'b1);
        send_text("-");
        send_text("=");

        rand_start = fed_count;
        while (fed_count - rand_start < RAND_ITEMS) begin
            if (!stall_done && fed_count - rand_start >= 80) begin
                stall_done = 1'b1;
                stall_asks++;
            end
            if (!pause_done && fed_count - rand_start >= 260) begin
                pause_done = 1'b1;
                wait_drained();
            end
            tx_idling = !(fed_count - rand_start >= 150 && fed_count - rand_start < 230);
            rx_idling = tx_idling;
            build_message();
            send_msg();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
